// ===== src/dgsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dense graph shortest path: shared constants
// Field widths, the infinity distance and the result status codes.
// ----------------------------------------------------------------------------
package dgsp_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_W = 6;
	localparam int DIST_W = 15;
	localparam int CFG_W = 7;
	localparam int STAT_W = 2;

	localparam logic [DIST_W-1:0] INF_DIST = 15'h7FFF;

	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] ST_PATH = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNREACH = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAME = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_ID = 2'd3;

endpackage
`default_nettype wire

// ===== src/dense_graph_shortest_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Dense graph shortest path
// Adjacency matrix in a synchronous memory with dense Dijkstra queries.
// ----------------------------------------------------------------------------
// Usage: an item is taken on a rising edge with start high and busy low.
// req_type selects add edge (with valid ids both mirrored matrix entries
// are written, busy during the second write, no result) or a query from
// node_a to node_b. A query returns its beats on the result ports, each
// valid for exactly one cycle while out_valid is high; last marks the final
// beat. The path is given from the target's predecessor back to the
// source, one node a beat. For a query, bad ids, source equal to target and
// an unreachable target give one beat; an edge with a bad id is ignored.
// Timing: each Dijkstra step scans one matrix row at one entry a cycle
// through the edge and distance memory ports, for the n nodes in use; then
// the final distance is read, and each path beat reads one predecessor word.
// Bad ids and source equal to target answer in the cycle after acceptance.
// Reset: after reset the whole matrix of MAX_NODES * MAX_NODES entries is
// cleared while busy is high; cfg_we writes node_count at any time. The
// receiver cannot stall, so beats are never held back.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path #(
	parameter int MAX_NODES = dgsp_pkg::MAX_NODES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [dgsp_pkg::CFG_W-1:0]    cfg_data,
	input  wire                          start,
	output logic                         busy,
	input  wire                          req_type,
	input  wire [dgsp_pkg::NODE_W-1:0]   node_a,
	input  wire [dgsp_pkg::NODE_W-1:0]   node_b,
	input  wire [dgsp_pkg::DIST_W-1:0]   edge_distance,
	output logic                         out_valid,
	output logic [dgsp_pkg::NODE_W-1:0]  path_node,
	output logic [dgsp_pkg::DIST_W-1:0]  total_distance,
	output logic [dgsp_pkg::STAT_W-1:0]  status,
	output logic                         last
);

	localparam int IDW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int DEPTH = MAX_NODES * MAX_NODES;
	localparam int AW = $clog2(DEPTH);
	localparam int DW = dgsp_pkg::DIST_W;
	localparam int CFW = dgsp_pkg::CFG_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EDGE2 = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;
	localparam logic [2:0] S_DCHK = 3'd5;
	localparam logic [2:0] S_TRD = 3'd6;
	localparam logic [2:0] S_TOUT = 3'd7;

	logic [2:0] state_q;
	logic [CFW-1:0] node_count_q;
	logic [AW-1:0] clear_q;

	logic [DW:0] edge_mem [DEPTH];
	logic [IDW+DW-1:0] dist_mem [MAX_NODES];

	logic [DW:0] edge_rd;
	logic [IDW+DW-1:0] dist_word_rd;
	logic [DW-1:0] dist_rd;
	logic [IDW-1:0] pred_rd;

	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] dvalid_q;

	logic [IDW-1:0] src_q, dst_q, cur_q, cand_q;
	logic [DW-1:0] cur_dist_q, cand_dist_q, ew_q;
	logic [CW-1:0] j_q;
	logic [IDW-1:0] j_s1;
	logic v_s1;

	logic out_valid_q, last_q;
	logic [dgsp_pkg::NODE_W-1:0] path_node_q;
	logic [DW-1:0] total_q;
	logic [dgsp_pkg::STAT_W-1:0] status_q;

	// Node count in use, clamped to the supported range.
	logic [CW-1:0] n_eff;
	always_comb begin
		if (node_count_q < CFW'(2))
			n_eff = CW'(2);
		else if (node_count_q > CFW'(MAX_NODES))
			n_eff = CW'(MAX_NODES);
		else
			n_eff = CW'(node_count_q);
	end

	logic accept, a_ok, b_ok;
	logic [IDW-1:0] a_id, b_id;
	assign accept = start && !busy;
	assign a_ok = {1'b0, node_a} < {1'b0, CFW'(n_eff)};
	assign b_ok = {1'b0, node_b} < {1'b0, CFW'(n_eff)};
	assign a_id = node_a[IDW-1:0];
	assign b_id = node_b[IDW-1:0];

	// Edge memory port selection.
	logic edge_we;
	logic [AW-1:0] edge_waddr, edge_raddr;
	logic [DW:0] edge_wdata;
	always_comb begin
		edge_we = 1'b0;
		edge_waddr = clear_q;
		edge_wdata = '0;
		if (state_q == S_CLEAR) begin
			edge_we = 1'b1;
		end else if (state_q == S_EDGE2) begin
			edge_we = 1'b1;
			edge_waddr = AW'(dst_q) * AW'(MAX_NODES) + AW'(src_q);
			edge_wdata = {1'b1, ew_q};
		end else if (accept && req_type == dgsp_pkg::REQ_EDGE && a_ok && b_ok) begin
			edge_we = 1'b1;
			edge_waddr = AW'(a_id) * AW'(MAX_NODES) + AW'(b_id);
			edge_wdata = {1'b1, edge_distance};
		end
	end
	assign edge_raddr = AW'(cur_q) * AW'(MAX_NODES) + AW'(j_q[IDW-1:0]);

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_waddr] <= edge_wdata;
		edge_rd <= edge_mem[edge_raddr];
	end

	// Relaxation of the entry read in the previous cycle.
	logic [DW:0] sum_wide;
	logic [DW-1:0] sum_sat, d_old, d_new;
	logic vis_s1, upd;
	always_comb begin
		sum_wide = {1'b0, cur_dist_q} + {1'b0, edge_rd[DW-1:0]};
		sum_sat = (sum_wide > {1'b0, dgsp_pkg::INF_DIST}) ? dgsp_pkg::INF_DIST
			: sum_wide[DW-1:0];
		d_old = dvalid_q[j_s1] ? dist_rd : dgsp_pkg::INF_DIST;
		vis_s1 = visited_q[j_s1];
		upd = v_s1 && edge_rd[DW] && !vis_s1 && (d_old > sum_sat);
		d_new = upd ? sum_sat : d_old;
	end

	logic start_query;
	assign start_query = accept && req_type == dgsp_pkg::REQ_QUERY && a_ok && b_ok
		&& node_a != node_b;

	// Distance and predecessor share one memory word per node.
	logic dist_we;
	logic [IDW-1:0] dist_waddr, dist_raddr;
	logic [IDW+DW-1:0] dist_wdata;
	always_comb begin
		dist_we = upd || start_query;
		dist_waddr = start_query ? a_id : j_s1;
		dist_wdata = start_query ? '0 : {cur_q, sum_sat};
		if (state_q == S_FIN)
			dist_raddr = dst_q;
		else if (state_q == S_TRD)
			dist_raddr = cur_q;
		else
			dist_raddr = j_q[IDW-1:0];
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_waddr] <= dist_wdata;
		dist_word_rd <= dist_mem[dist_raddr];
	end
	assign dist_rd = dist_word_rd[DW-1:0];
	assign pred_rd = dist_word_rd[IDW+DW-1:DW];

	logic scan_issue, scan_done;
	assign scan_issue = (state_q == S_SCAN) && (j_q < n_eff);
	assign scan_done = (state_q == S_SCAN) && (j_q == n_eff) && !v_s1;

	logic [DW-1:0] fin_dist;
	assign fin_dist = dvalid_q[dst_q] ? dist_rd : dgsp_pkg::INF_DIST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clear_q <= '0;
			node_count_q <= CFW'(64);
			visited_q <= '0;
			dvalid_q <= '0;
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				node_count_q <= cfg_data;
			v_s1 <= scan_issue;
			out_valid_q <= 1'b0;
			if (upd)
				dvalid_q[j_s1] <= 1'b1;
			case (state_q)
				S_CLEAR: begin
					clear_q <= clear_q + AW'(1);
					if (clear_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req_type == dgsp_pkg::REQ_EDGE) begin
							if (a_ok && b_ok)
								state_q <= S_EDGE2;
						end else if (!(a_ok && b_ok)) begin
							out_valid_q <= 1'b1;
						end else if (node_a == node_b) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
							visited_q <= '0;
							dvalid_q <= MAX_NODES'(1) << a_id;
						end
					end
				end
				S_EDGE2: state_q <= S_IDLE;
				S_SCAN: begin
					if (scan_done) begin
						if (cur_q == dst_q) begin
							state_q <= S_FIN;
						end else begin
							visited_q[cur_q] <= 1'b1;
							if (cand_dist_q == dgsp_pkg::INF_DIST)
								state_q <= S_FIN;
						end
					end
				end
				S_FIN: state_q <= S_DCHK;
				S_DCHK: begin
					if (fin_dist == dgsp_pkg::INF_DIST) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TRD;
					end
				end
				S_TRD: state_q <= S_TOUT;
				S_TOUT: begin
					out_valid_q <= 1'b1;
					state_q <= (pred_rd == src_q) ? S_IDLE : S_TRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		j_s1 <= j_q[IDW-1:0];
		if (scan_issue)
			j_q <= j_q + CW'(1);
		if (v_s1 && !vis_s1 && j_s1 != cur_q && d_new < cand_dist_q) begin
			cand_q <= j_s1;
			cand_dist_q <= d_new;
		end
		case (state_q)
			S_IDLE: begin
				src_q <= a_id;
				dst_q <= b_id;
				ew_q <= edge_distance;
				cur_q <= a_id;
				cur_dist_q <= '0;
				j_q <= '0;
				cand_dist_q <= dgsp_pkg::INF_DIST;
				if (!(a_ok && b_ok)) begin
					path_node_q <= '0;
					total_q <= dgsp_pkg::INF_DIST;
					status_q <= dgsp_pkg::ST_BAD_ID;
				end else begin
					path_node_q <= node_a;
					total_q <= '0;
					status_q <= dgsp_pkg::ST_SAME;
				end
				last_q <= 1'b1;
			end
			S_SCAN: begin
				if (scan_done && cur_q != dst_q) begin
					cur_q <= cand_q;
					cur_dist_q <= cand_dist_q;
					j_q <= '0;
					cand_dist_q <= dgsp_pkg::INF_DIST;
				end
			end
			S_DCHK: begin
				cur_q <= dst_q;
				total_q <= fin_dist;
				path_node_q <= '0;
				status_q <= dgsp_pkg::ST_UNREACH;
				last_q <= 1'b1;
			end
			S_TOUT: begin
				cur_q <= pred_rd;
				path_node_q <= dgsp_pkg::NODE_W'(pred_rd);
				status_q <= dgsp_pkg::ST_PATH;
				last_q <= (pred_rd == src_q);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign total_distance = total_q;
	assign status = status_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ({1'b0, j_s1} < {1'b0, CW'(n_eff)}))
		else $error("scan index beyond node count");
	a_cur_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !visited_q[cur_q])
		else $error("scanning from a visited node");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != dgsp_pkg::ST_PATH) |-> last)
		else $error("status beat without last");
	a_path_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == dgsp_pkg::ST_PATH) |-> (total_distance != dgsp_pkg::INF_DIST))
		else $error("path beat with infinite distance");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> !busy || $past(accept))
		else $error("busy after final beat");
`endif

endmodule
`default_nettype wire
